// ----- hdl/lrs_pkg.sv -----
// ---------------------------------------------------------------------------
// lrs_pkg: shared types and constants for the Life row step core
// Row width, field widths, register indexes, result word and tail states.
// ---------------------------------------------------------------------------
package lrs_pkg;

   localparam int ROW_W          = 64;   // cells per row word
   localparam int IDX_W          = 10;   // row index width
   localparam int WID_W          = 7;    // width_in_use register width
   localparam int HGT_W          = 11;   // height_in_use register width
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 11;
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int MIN_DIM        = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_IN_USE = 1'b1;

   localparam logic [WID_W-1:0] WIDTH_RESET  = 7'd64;
   localparam logic [HGT_W-1:0] HEIGHT_RESET = 11'd1024;

   typedef struct packed {
      logic [ROW_W-1:0] next_cells;
      logic [IDX_W-1:0] row_index;
      logic             frame_done;
   } rsp_word_type;

   // extra result words owed after the last row of a frame
   typedef enum logic [1:0] {
      TAIL_IDLE,
      TAIL_LAST,
      TAIL_WRAP
   } tail_state_type;

   // bit k set for every column below the width in use
   function automatic logic [ROW_W-1:0] row_mask(input logic [WID_W-1:0] w);
      logic [ROW_W-1:0] m;
      for (int k = 0; k < ROW_W; k++) begin
         m[k] = (WID_W'(k) < w);
      end
      return m;
   endfunction

endpackage

// ----- hdl/lrs_cell.sv -----
// ---------------------------------------------------------------------------
// lrs_cell: one lane of the row evaluator
// Applies the Life rule to one cell from its 3x3 neighborhood.
// ---------------------------------------------------------------------------
module lrs_cell (
   input  logic [2:0] up_bits,
   input  logic [2:0] mid_bits,
   input  logic [2:0] down_bits,
   output logic       alive
);

   logic [3:0] sum;
   logic [4:0] score;

   always_comb begin
      sum = 4'(up_bits[0]) + 4'(up_bits[1]) + 4'(up_bits[2])
          + 4'(mid_bits[0]) + 4'(mid_bits[1]) + 4'(mid_bits[2])
          + 4'(down_bits[0]) + 4'(down_bits[1]) + 4'(down_bits[2]);
      // doubled sum minus the center cell
      score = {sum, 1'b0} - {4'd0, mid_bits[1]};
      alive = (score > 5'd4) && (score < 5'd8);
   end

endmodule

// ----- hdl/lrs_row_eval.sv -----
// ---------------------------------------------------------------------------
// lrs_row_eval: full-row evaluator
// One lane per column with horizontal wrap at the width in use; the lane
// outputs are merged into the next-generation row word.
// ---------------------------------------------------------------------------
module lrs_row_eval (
   input  logic [lrs_pkg::ROW_W-1:0] up_row,
   input  logic [lrs_pkg::ROW_W-1:0] mid_row,
   input  logic [lrs_pkg::ROW_W-1:0] down_row,
   input  logic [lrs_pkg::WID_W-1:0] width,
   output logic [lrs_pkg::ROW_W-1:0] next_row
);

   localparam int ROW_W = lrs_pkg::ROW_W;
   localparam int COL_W = $clog2(ROW_W);

   logic [ROW_W-1:0] mask;
   logic [COL_W-1:0] last_col;
   logic [ROW_W-1:0] up_m, mid_m, down_m;
   logic [ROW_W-1:0] up_l, mid_l, down_l;
   logic [ROW_W-1:0] up_r, mid_r, down_r;
   logic [ROW_W-1:0] lane_alive;

   always_comb begin
      mask     = lrs_pkg::row_mask(width);
      last_col = COL_W'(width - lrs_pkg::WID_W'(1));
      up_m     = up_row & mask;
      mid_m    = mid_row & mask;
      down_m   = down_row & mask;
      for (int x = 0; x < ROW_W; x++) begin
         if (x == 0) begin
            up_l[x]   = up_m[last_col];
            mid_l[x]  = mid_m[last_col];
            down_l[x] = down_m[last_col];
         end else begin
            up_l[x]   = up_m[x-1];
            mid_l[x]  = mid_m[x-1];
            down_l[x] = down_m[x-1];
         end
         if (x == ROW_W-1 || COL_W'(x) == last_col) begin
            up_r[x]   = up_m[0];
            mid_r[x]  = mid_m[0];
            down_r[x] = down_m[0];
         end else begin
            up_r[x]   = up_m[(x+1) % ROW_W];
            mid_r[x]  = mid_m[(x+1) % ROW_W];
            down_r[x] = down_m[(x+1) % ROW_W];
         end
      end
   end

   for (genvar x = 0; x < ROW_W; x++) begin : g_lane
      lrs_cell u_cell (
         .up_bits   ({up_r[x],   up_m[x],   up_l[x]}),
         .mid_bits  ({mid_r[x],  mid_m[x],  mid_l[x]}),
         .down_bits ({down_r[x], down_m[x], down_l[x]}),
         .alive     (lane_alive[x])
      );
   end

   // merge: columns past the width read zero
   assign next_row = lane_alive & mask;

endmodule

// ----- hdl/lrs_out_queue.sv -----
// ---------------------------------------------------------------------------
// lrs_out_queue: two-entry result queue
// Decouples the evaluator from a stalling receiver.
// ---------------------------------------------------------------------------
module lrs_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lrs_pkg::rsp_word_type push_word,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lrs_pkg::rsp_word_type rsp_word
);

   lrs_pkg::rsp_word_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_word  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- hdl/life_automaton_row_step_core.sv -----
// ---------------------------------------------------------------------------
// life_automaton_row_step_core: streaming toroidal Life generation step
// Takes grid rows in order and returns next-generation rows.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one row word per accepted cycle (valid/stall handshake).
//   rsp_* returns next-generation row words with their row index; the
//   word for row 0 closes the frame and has rsp_frame_done set.
//   csr_* writes width_in_use (index 0) and height_in_use (index 1);
//   write only while the core is idle.
// Output: a result word is pushed into the result queue in the cycle the row
//   that completes it is accepted, and rsp_* shows the oldest queued word.
// Throughput: one row per cycle while req_stall is low. Rows 0 and 1 give
//   no word, each later row gives one; the last row of a frame gives three,
//   and the two extra words go through the single row evaluator in the
//   TAIL_LAST and TAIL_WRAP states while req_stall is held high.
// Reset: width 64, height 1024, row store cleared, frame restarts at row 0.
// Stalling: a two-word result queue keeps rows flowing while the receiver
//   holds rsp_stall; req_stall rises when the queue is full.
// ---------------------------------------------------------------------------
module life_automaton_row_step_core #(
   parameter int MAX_WIDTH  = lrs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lrs_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [lrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lrs_pkg::ROW_W-1:0]      req_row_cells,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lrs_pkg::ROW_W-1:0]      rsp_next_cells,
   output logic [lrs_pkg::IDX_W-1:0]      rsp_row_index,
   output logic                           rsp_frame_done
);

   localparam int ROW_W = lrs_pkg::ROW_W;
   localparam int IDX_W = lrs_pkg::IDX_W;
   localparam int WID_W = lrs_pkg::WID_W;
   localparam int HGT_W = lrs_pkg::HGT_W;
   localparam int WCAP  = (MAX_WIDTH < ROW_W) ? MAX_WIDTH : ROW_W;
   localparam int HCAP  = (MAX_HEIGHT < (1 << IDX_W)) ? MAX_HEIGHT : (1 << IDX_W);

   logic [WID_W-1:0] width_ff, width_in;
   logic [HGT_W-1:0] height_ff, height_in;
   logic [WID_W-1:0] width_eff;
   logic [HGT_W-1:0] height_eff;

   logic [ROW_W-1:0] first_ff, first_in;
   logic [ROW_W-1:0] second_ff, second_in;
   logic [ROW_W-1:0] older_ff, older_in;
   logic [ROW_W-1:0] newer_ff, newer_in;
   logic [IDX_W-1:0] rows_seen_ff, rows_seen_in;
   logic [IDX_W-1:0] tail_idx_ff, tail_idx_in;

   lrs_pkg::tail_state_type tail_ff, tail_in;

   logic             accept;
   logic             last_row;
   logic             queue_full;
   logic [ROW_W-1:0] row_masked;

   logic             eval_go;
   logic [ROW_W-1:0] eval_up, eval_mid, eval_down;
   logic [ROW_W-1:0] eval_row;
   lrs_pkg::rsp_word_type push_word, rsp_word;

   // ---- configuration ----
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            lrs_pkg::CSR_WIDTH_IN_USE:  width_in  = csr_write_data[WID_W-1:0];
            lrs_pkg::CSR_HEIGHT_IN_USE: height_in = csr_write_data[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < WID_W'(lrs_pkg::MIN_DIM)) begin
         width_eff = WID_W'(lrs_pkg::MIN_DIM);
      end else if (width_ff > WID_W'(WCAP)) begin
         width_eff = WID_W'(WCAP);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff < HGT_W'(lrs_pkg::MIN_DIM)) begin
         height_eff = HGT_W'(lrs_pkg::MIN_DIM);
      end else if (height_ff > HGT_W'(HCAP)) begin
         height_eff = HGT_W'(HCAP);
      end else begin
         height_eff = height_ff;
      end
   end

   // ---- input acceptance and row store ----
   assign req_stall  = (tail_ff != lrs_pkg::TAIL_IDLE) || queue_full;
   assign accept     = req_valid && !req_stall;
   assign row_masked = req_row_cells & lrs_pkg::row_mask(width_eff);
   assign last_row   = {1'b0, rows_seen_ff} >= (height_eff - HGT_W'(1));

   always_comb begin
      first_in     = first_ff;
      second_in    = second_ff;
      older_in     = older_ff;
      newer_in     = newer_ff;
      rows_seen_in = rows_seen_ff;
      tail_idx_in  = tail_idx_ff;
      if (accept) begin
         if (rows_seen_ff == IDX_W'(0)) begin
            first_in     = row_masked;
            newer_in     = row_masked;
            rows_seen_in = IDX_W'(1);
         end else if (rows_seen_ff == IDX_W'(1)) begin
            second_in    = row_masked;
            older_in     = newer_ff;
            newer_in     = row_masked;
            rows_seen_in = IDX_W'(2);
         end else begin
            older_in    = newer_ff;
            newer_in    = row_masked;
            tail_idx_in = rows_seen_ff;
            rows_seen_in = last_row ? IDX_W'(0) : rows_seen_ff + IDX_W'(1);
         end
      end
   end

   // ---- tail sequencer: next state ----
   always_comb begin
      tail_in = tail_ff;
      case (tail_ff)
         lrs_pkg::TAIL_IDLE: begin
            if (accept && rows_seen_ff >= IDX_W'(2) && last_row) begin
               tail_in = lrs_pkg::TAIL_LAST;
            end
         end
         lrs_pkg::TAIL_LAST: begin
            if (!queue_full) begin
               tail_in = lrs_pkg::TAIL_WRAP;
            end
         end
         lrs_pkg::TAIL_WRAP: begin
            if (!queue_full) begin
               tail_in = lrs_pkg::TAIL_IDLE;
            end
         end
         default: tail_in = lrs_pkg::TAIL_IDLE;
      endcase
   end

   // ---- tail sequencer: evaluator source and result word ----
   always_comb begin
      eval_go   = 1'b0;
      eval_up   = older_ff;
      eval_mid  = newer_ff;
      eval_down = row_masked;
      push_word.row_index  = rows_seen_ff - IDX_W'(1);
      push_word.frame_done = 1'b0;
      case (tail_ff)
         lrs_pkg::TAIL_IDLE: begin
            eval_go = accept && (rows_seen_ff >= IDX_W'(2));
         end
         lrs_pkg::TAIL_LAST: begin
            // older/newer already shifted: the last row sits in newer
            eval_go   = !queue_full;
            eval_down = first_ff;
            push_word.row_index = tail_idx_ff;
         end
         lrs_pkg::TAIL_WRAP: begin
            eval_go   = !queue_full;
            eval_up   = newer_ff;
            eval_mid  = first_ff;
            eval_down = second_ff;
            push_word.row_index  = IDX_W'(0);
            push_word.frame_done = 1'b1;
         end
         default: eval_go = 1'b0;
      endcase
      push_word.next_cells = eval_row;
   end

   lrs_row_eval u_row_eval (
      .up_row   (eval_up),
      .mid_row  (eval_mid),
      .down_row (eval_down),
      .width    (width_eff),
      .next_row (eval_row)
   );

   lrs_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (eval_go),
      .push_word (push_word),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_next_cells = rsp_word.next_cells;
   assign rsp_row_index  = rsp_word.row_index;
   assign rsp_frame_done = rsp_word.frame_done;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= lrs_pkg::WIDTH_RESET;
         height_ff    <= lrs_pkg::HEIGHT_RESET;
         first_ff     <= '0;
         second_ff    <= '0;
         older_ff     <= '0;
         newer_ff     <= '0;
         rows_seen_ff <= '0;
         tail_ff      <= lrs_pkg::TAIL_IDLE;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         rows_seen_ff <= rows_seen_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_idx_ff <= tail_idx_in;
   end

   // ---- assertions ----
   a_last_row_starts_tail: assert property (@(posedge clock) disable iff (reset)
      (accept && rows_seen_ff >= IDX_W'(2) && last_row) |=>
         (tail_ff == lrs_pkg::TAIL_LAST && rows_seen_ff == IDX_W'(0)))
      else $error("last row did not start the frame tail");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      eval_go |-> !queue_full)
      else $error("result word pushed into a full queue");

   a_done_on_row_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_row_index == IDX_W'(0)))
      else $error("frame_done on a row other than row 0");

   a_wrap_at_frame_start: assert property (@(posedge clock) disable iff (reset)
      (tail_ff == lrs_pkg::TAIL_WRAP) |-> (rows_seen_ff == IDX_W'(0)))
      else $error("wrap word pending outside frame start");

endmodule

// ----- bench/life_row_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// life_row_checker: scoreboard for the Life row step core
// Watches the register port and both channels, works out the next-generation
// rows each accepted row word completes, and compares them with the result
// words in order.
// ---------------------------------------------------------------------------
module life_row_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [lrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [lrs_pkg::ROW_W-1:0]      req_row_cells,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [lrs_pkg::ROW_W-1:0]      rsp_next_cells,
   input  logic [lrs_pkg::IDX_W-1:0]      rsp_row_index,
   input  logic                           rsp_frame_done,
   output int                             mismatch_count,
   output int                             words_owed
);

   localparam int ROW_W = lrs_pkg::ROW_W;
   localparam int IDX_W = lrs_pkg::IDX_W;
   localparam int WID_W = lrs_pkg::WID_W;
   localparam int HGT_W = lrs_pkg::HGT_W;

   lrs_pkg::rsp_word_type due_rows_q[$];
   lrs_pkg::rsp_word_type due;
   logic [WID_W-1:0]      width_reg;
   logic [HGT_W-1:0]      height_reg;
   logic [ROW_W-1:0]      top_row;
   logic [ROW_W-1:0]      second_row;
   logic [ROW_W-1:0]      older_row;
   logic [ROW_W-1:0]      newer_row;
   logic [IDX_W-1:0]      next_row_idx;

   function automatic int cells_per_row(input logic [WID_W-1:0] w);
      int v;
      v = w;
      if (v < lrs_pkg::MIN_DIM) v = lrs_pkg::MIN_DIM;
      if (v > lrs_pkg::DEF_MAX_WIDTH) v = lrs_pkg::DEF_MAX_WIDTH;
      return v;
   endfunction

   function automatic int rows_per_frame(input logic [HGT_W-1:0] h);
      int v;
      v = h;
      if (v < lrs_pkg::MIN_DIM) v = lrs_pkg::MIN_DIM;
      if (v > lrs_pkg::DEF_MAX_HEIGHT) v = lrs_pkg::DEF_MAX_HEIGHT;
      return v;
   endfunction

   function automatic logic [ROW_W-1:0] cells_mask(input int w);
      return (w >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << w) - ROW_W'(1));
   endfunction

   // one generation of the middle row, columns wrap modulo w
   function automatic logic [ROW_W-1:0] life_next_row(
      input logic [ROW_W-1:0] up,
      input logic [ROW_W-1:0] mid,
      input logic [ROW_W-1:0] down,
      input int               w
   );
      logic [ROW_W-1:0] a, b, c, m, res;
      int x, xl, xr, s, v;
      m   = cells_mask(w);
      a   = up & m;
      b   = mid & m;
      c   = down & m;
      res = '0;
      for (x = 0; x < w; x++) begin
         xl = (x == 0) ? w - 1 : x - 1;
         xr = (x == w - 1) ? 0 : x + 1;
         s  = int'(a[xl]) + int'(a[x]) + int'(a[xr])
            + int'(b[xl]) + int'(b[x]) + int'(b[xr])
            + int'(c[xl]) + int'(c[x]) + int'(c[xr]);
         v  = 2 * s - int'(b[x]);
         if (v > 4 && v < 8) res[x] = 1'b1;
      end
      return res;
   endfunction

   task automatic queue_word(input logic [ROW_W-1:0] cells, input int idx,
                             input logic done);
      lrs_pkg::rsp_word_type word;
      word.next_cells = cells;
      word.row_index  = IDX_W'(idx);
      word.frame_done = done;
      due_rows_q.push_back(word);
   endtask

   task automatic take_row(input logic [ROW_W-1:0] cells);
      int               w, h, r;
      logic [ROW_W-1:0] row;
      w   = cells_per_row(width_reg);
      h   = rows_per_frame(height_reg);
      row = cells & cells_mask(w);
      r   = next_row_idx;
      if (r == 0) begin
         top_row      = row;
         newer_row    = row;
         next_row_idx = 1;
      end else if (r == 1) begin
         second_row   = row;
         older_row    = newer_row;
         newer_row    = row;
         next_row_idx = 2;
      end else begin
         queue_word(life_next_row(older_row, newer_row, row, w), r - 1, 1'b0);
         // last row of the frame (or past it after the height was lowered)
         if (r >= h - 1) begin
            queue_word(life_next_row(newer_row, row, top_row, w), r, 1'b0);
            queue_word(life_next_row(row, top_row, second_row, w), 0, 1'b1);
            next_row_idx = '0;
         end else begin
            next_row_idx = IDX_W'(r + 1);
         end
         older_row = newer_row;
         newer_row = row;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg      = lrs_pkg::WIDTH_RESET;
         height_reg     = lrs_pkg::HEIGHT_RESET;
         top_row        = '0;
         second_row     = '0;
         older_row      = '0;
         newer_row      = '0;
         next_row_idx   = '0;
         mismatch_count = 0;
         due_rows_q.delete();
      end else begin
         // a row taken at this edge still sees the old register values
         if (req_valid && !req_stall) take_row(req_row_cells);
         if (csr_write_en) begin
            if (csr_index == lrs_pkg::CSR_WIDTH_IN_USE)
               width_reg = csr_write_data[WID_W-1:0];
            else if (csr_index == lrs_pkg::CSR_HEIGHT_IN_USE)
               height_reg = csr_write_data[HGT_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_rows_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected word: cells %h row %0d done %b", $realtime,
                           rsp_next_cells, rsp_row_index, rsp_frame_done);
               mismatch_count++;
            end else begin
               due = due_rows_q.pop_front();
               if (due.next_cells !== rsp_next_cells || due.row_index !== rsp_row_index ||
                   due.frame_done !== rsp_frame_done) begin
                  if (mismatch_count < 10)
                     $display("%0t: word mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              $realtime, due.next_cells, due.row_index, due.frame_done,
                              rsp_next_cells, rsp_row_index, rsp_frame_done);
                  mismatch_count++;
               end
            end
         end
      end
      words_owed <= due_rows_q.size();
   end

endmodule

// ----- bench/tb_life_automaton_row_step_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_life_automaton_row_step_core: testbench for the Life row step core
// Streams frames of grid rows under many width/height settings, including
// out-of-range values and mid-frame changes, with random gaps on both sides;
// a checker module beside the core scores every result word.
// ---------------------------------------------------------------------------
module tb_life_automaton_row_step_core;

   localparam int ROW_W       = lrs_pkg::ROW_W;
   localparam int IDX_W       = lrs_pkg::IDX_W;
   localparam int CSR_IDX_W   = lrs_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = lrs_pkg::CSR_DATA_W;
   localparam int QUIET_LIMIT = 1000;
   localparam int ROW_TARGET  = 450;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [ROW_W-1:0]      req_row_cells;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ROW_W-1:0]      rsp_next_cells;
   logic [IDX_W-1:0]      rsp_row_index;
   logic                  rsp_frame_done;

   int mismatch_total;
   int words_owed;
   int quiet_cycles;
   int rows_sent     = 0;
   int req_idle_mode = 0;
   int rsp_idle_mode = 0;

   life_automaton_row_step_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_cells  (req_row_cells),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_cells (rsp_next_cells),
      .rsp_row_index  (rsp_row_index),
      .rsp_frame_done (rsp_frame_done)
   );

   life_row_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_cells  (req_row_cells),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_cells (rsp_next_cells),
      .rsp_row_index  (rsp_row_index),
      .rsp_frame_done (rsp_frame_done),
      .mismatch_count (mismatch_total),
      .words_owed     (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mode 0: never idle, 1: a random gap every time, 2: mostly back to back
   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(17, 0);
         default: return ($urandom_range(7, 0) == 0) ? $urandom_range(17, 0) : 0;
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] random_row();
      logic [ROW_W-1:0] a, b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(4, 0))
         0: return a & b;
         1: return a | b;
         2: return a & b & {$urandom, $urandom};
         default: return a;
      endcase
   endfunction

   function automatic int pick_width();
      case ($urandom_range(9, 0))
         0: return $urandom_range(127, 0);
         1: return 64;
         2: return 3;
         default: return $urandom_range(64, 3);
      endcase
   endfunction

   // receiver: stall a drawn number of cycles, then take one word
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      forever begin
         gap = draw_gap(rsp_idle_mode);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_row(input logic [ROW_W-1:0] cells);
      int gap;
      gap = draw_gap(req_idle_mode);
      if (gap > 0) begin
         req_valid     <= 1'b0;
         req_row_cells <= random_row();
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_row_cells <= cells;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rows_sent++;
   endtask

   // both registers, back to back; write enable stays high across the pair
   task automatic load_frame_shape(input int width, input int height);
      csr_write_en   <= 1'b1;
      csr_index      <= lrs_pkg::CSR_WIDTH_IN_USE;
      csr_write_data <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_index      <= lrs_pkg::CSR_HEIGHT_IN_USE;
      csr_write_data <= CSR_DATA_W'(height);
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // rows 0 and 1 leave no word behind, so wait on past the point where none is owed
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int wid, hgt, depth;
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= lrs_pkg::CSR_WIDTH_IN_USE;
      csr_write_data <= '0;
      req_valid      <= 1'b0;
      req_row_cells  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset shape, then height lowered below the current row
      send_row('0);
      send_row({ROW_W{1'b1}});
      send_row({16{4'h5}});
      send_row({16{4'hA}});
      send_row(random_row());
      wait_drained();
      load_frame_shape(64, 3);
      send_row({ROW_W{1'b1}});
      wait_drained();

      // narrowest grid, bits above the width must be dropped
      load_frame_shape(3, 3);
      send_row(64'h7);
      send_row(64'h5);
      send_row({ROW_W{1'b1}});
      wait_drained();

      // below-range settings saturate up
      load_frame_shape(0, 0);
      repeat (3) send_row(random_row());
      wait_drained();
      load_frame_shape(2, 2);
      repeat (3) send_row(random_row());
      wait_drained();

      // above-range settings, then width changed mid-frame, then closed early
      load_frame_shape(127, 2047);
      repeat (4) send_row(random_row());
      wait_drained();
      load_frame_shape(5, 2047);
      send_row({ROW_W{1'b1}});
      send_row(random_row());
      wait_drained();
      load_frame_shape(65, 1);
      send_row(random_row());
      wait_drained();

      while (rows_sent < ROW_TARGET) begin
         req_idle_mode = $urandom_range(2, 0);
         rsp_idle_mode = $urandom_range(2, 0);
         wid = pick_width();
         if ($urandom_range(4, 0) != 0) begin
            if ($urandom_range(9, 0) == 0) hgt = $urandom_range(2, 0);
            else if ($urandom_range(4, 0) == 0) hgt = $urandom_range(40, 13);
            else hgt = $urandom_range(12, 3);
            load_frame_shape(wid, hgt);
            repeat ((hgt < lrs_pkg::MIN_DIM) ? lrs_pkg::MIN_DIM : hgt)
               send_row(random_row());
            wait_drained();
         end else begin
            // partial frame, then shape changed so the next row closes it
            hgt   = ($urandom_range(1, 0) == 0) ? $urandom_range(2047, 1025)
                                                : $urandom_range(40, 23);
            depth = $urandom_range(20, 2);
            load_frame_shape(wid, hgt);
            repeat (depth) send_row(random_row());
            wait_drained();
            load_frame_shape(pick_width(), $urandom_range(depth + 1, 0));
            send_row(random_row());
            wait_drained();
         end
      end

      wait_drained();
      if (mismatch_total == 0 && words_owed == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
